>>> src/ogfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ogfc_pkg
// Shared types, codes and constants of the occupancy grid frontier classifier.
// ----------------------------------------------------------------------------
package ogfc_pkg;

    // grid side default and signed coordinate width for window walks
    localparam int GRID_SIDE_DEF = 64;
    localparam int CW            = 12;

    // field widths
    localparam int MODE_W  = 2;
    localparam int COORD_W = 6;
    localparam int OCC_W   = 8;
    localparam int CLS_W   = 2;
    localparam int CFG_AW  = 3;
    localparam int CFG_DW  = 8;
    localparam int RANGE_W = 5;
    localparam int FW_W    = 2;
    localparam int DW_W    = 3;
    localparam int RAD_W   = 3;
    localparam int IN_DW   = 24;
    localparam int OUT_DW  = 8;

    // item modes
    localparam logic [MODE_W-1:0] MODE_WRITE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_UPDATE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

    // occupancy classes
    localparam logic [CLS_W-1:0] OCC_UNEXPLORED = 2'd0;
    localparam logic [CLS_W-1:0] OCC_FREE       = 2'd1;
    localparam logic [CLS_W-1:0] OCC_OCCUPIED   = 2'd2;

    // planning classes
    localparam logic [CLS_W-1:0] PLAN_REGULAR  = 2'd0;
    localparam logic [CLS_W-1:0] PLAN_FRONTIER = 2'd1;
    localparam logic [CLS_W-1:0] PLAN_DANGER   = 2'd2;

    // register indexes
    localparam logic [CFG_AW-1:0] REG_UPDATE_RANGE = 3'd0;
    localparam logic [CFG_AW-1:0] REG_OCC_THR      = 3'd1;
    localparam logic [CFG_AW-1:0] REG_FREE_THR     = 3'd2;
    localparam logic [CFG_AW-1:0] REG_FRONTIER_W   = 3'd3;
    localparam logic [CFG_AW-1:0] REG_DANGER_W     = 3'd4;

    // reset values
    localparam logic [RANGE_W-1:0] RANGE_RST   = 5'd8;
    localparam logic [OCC_W-1:0]   OCC_THR_RST = 8'd153;
    localparam logic [OCC_W-1:0]   FREE_THR_RST = 8'd76;
    localparam logic [FW_W-1:0]    FW_RST      = 2'd1;
    localparam logic [DW_W-1:0]    DW_RST      = 3'd3;
    localparam logic [OCC_W-1:0]   OCC_INIT    = 8'd128;

    typedef logic signed [CW-1:0] t_coord;

    // controller to datapath commands
    typedef struct packed {
        logic clr_step;
        logic load;
        logic res_zero;
        logic item_write;
        logic item_read;
        logic res_read;
        logic res_done;
        logic walk_issue;
        logic walk_adv;
        logic cell_eval;
        logic sweep_step;
        logic out_load;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic clr_last;
        logic walk_in;
        logic walk_last;
        logic eval_mark;
        logic sweep_last;
        logic out_free;
    } t_stat;

endpackage

>>> src/ogfc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ogfc_ctrl
// Controller state machine: clearing pass, item dispatch, window walk and
// neighborhood sweeps, result hand-off.
// ----------------------------------------------------------------------------
module ogfc_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    input  logic [ogfc_pkg::MODE_W-1:0] i_mode,
    input  ogfc_pkg::t_stat             i_st,
    output logic                        o_s_tready,
    output ogfc_pkg::t_cmd              o_cmd
);
    import ogfc_pkg::*;

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_WRITE  = 4'd2;
    localparam logic [3:0] S_READ   = 4'd3;
    localparam logic [3:0] S_RDATA  = 4'd4;
    localparam logic [3:0] S_WALK   = 4'd5;
    localparam logic [3:0] S_EVAL   = 4'd6;
    localparam logic [3:0] S_SWEEP  = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;
    localparam logic [3:0] S_FINISH = 4'd9;

    logic [3:0] r_state, n_state;
    logic       w_acc;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_acc      = i_s_tvalid && o_s_tready;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_st.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (w_acc) begin
                    o_cmd.load = 1'b1;
                    case (i_mode)
                        MODE_WRITE:  n_state = S_WRITE;
                        MODE_UPDATE: n_state = S_WALK;
                        MODE_READ:   n_state = S_READ;
                        default: begin
                            o_cmd.res_zero = 1'b1;
                            n_state        = S_FINISH;
                        end
                    endcase
                end
            end
            S_WRITE: begin
                o_cmd.item_write = 1'b1;
                o_cmd.res_done   = 1'b1;
                n_state          = S_FINISH;
            end
            S_READ: begin
                o_cmd.item_read = 1'b1;
                n_state         = S_RDATA;
            end
            S_RDATA: begin
                o_cmd.res_read = 1'b1;
                n_state        = S_FINISH;
            end
            S_WALK: begin
                o_cmd.walk_issue = 1'b1;
                if (i_st.walk_in) begin
                    n_state = S_EVAL;
                end else if (i_st.walk_last) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.walk_adv = 1'b1;
                end
            end
            S_EVAL: begin
                o_cmd.cell_eval = 1'b1;
                if (i_st.eval_mark) begin
                    n_state = S_SWEEP;
                end else if (i_st.walk_last) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.walk_adv = 1'b1;
                    n_state        = S_WALK;
                end
            end
            S_SWEEP: begin
                o_cmd.sweep_step = 1'b1;
                if (i_st.sweep_last) begin
                    if (i_st.walk_last) begin
                        n_state = S_DONE;
                    end else begin
                        o_cmd.walk_adv = 1'b1;
                        n_state        = S_WALK;
                    end
                end
            end
            S_DONE: begin
                o_cmd.res_done = 1'b1;
                n_state        = S_FINISH;
            end
            S_FINISH: begin
                if (i_st.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> src/ogfc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ogfc_dp
// Datapath: cell stores, config registers, walk and sweep coordinates,
// reclassification and the output register.
// ----------------------------------------------------------------------------
module ogfc_dp #(
    parameter int GRID_SIDE = ogfc_pkg::GRID_SIDE_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ogfc_pkg::t_cmd              i_cmd,
    output ogfc_pkg::t_stat             o_st,
    input  logic [ogfc_pkg::IN_DW-1:0]  i_s_tdata,
    input  logic                        i_cfg_we,
    input  logic [ogfc_pkg::CFG_AW-1:0] i_cfg_addr,
    input  logic [ogfc_pkg::CFG_DW-1:0] i_cfg_data,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [ogfc_pkg::OUT_DW-1:0] o_m_tdata
);
    import ogfc_pkg::*;

    localparam int AB    = $clog2(GRID_SIDE);
    localparam int AW    = 2 * AB;
    localparam int DEPTH = 1 << AW;

    typedef logic [AW-1:0] t_addr;

    function automatic logic in_grid(input t_coord x, input t_coord y);
        return (x >= 0) && (y >= 0) && (x < t_coord'(GRID_SIDE)) && (y < t_coord'(GRID_SIDE));
    endfunction

    function automatic t_addr cell_addr(input t_coord x, input t_coord y);
        return {y[AB-1:0], x[AB-1:0]};
    endfunction

    // stores
    logic [OCC_W-1:0] occ_mem [DEPTH];
    logic [CLS_W-1:0] cls_mem [DEPTH];
    logic [CLS_W-1:0] pln_mem [DEPTH];

    // config registers
    logic [RANGE_W-1:0] r_range;
    logic [OCC_W-1:0]   r_othr, r_fthr;
    logic [FW_W-1:0]    r_fw;
    logic [DW_W-1:0]    r_dw;

    // item and walk state
    logic [COORD_W-1:0] r_ix, r_iy;
    logic [OCC_W-1:0]   r_iocc;
    t_coord             r_wi, r_wj, r_nx, r_ny;
    logic [RAD_W-1:0]   r_rad;
    logic [CLS_W-1:0]   r_want, r_mark;
    logic [AW-1:0]      r_clr;
    logic               r_pv;
    t_addr              r_paddr;
    logic [OCC_W-1:0]   r_occ_rd;
    logic [CLS_W-1:0]   r_cls_rd, r_pln_rd;
    logic [CLS_W-1:0]   r_res_occ, r_res_pln;
    logic               r_res_done;
    logic               r_out_valid;
    logic [OUT_DW-1:0]  r_out_data;

    t_coord           w_ix, w_iy, w_rng, w_rad, w_lo_y, w_hi_x, w_hi_y;
    logic             w_item_in;
    t_addr            w_item_addr, w_walk_addr;
    logic [CLS_W-1:0] w_new_cls;
    logic             w_hit;

    assign w_ix        = t_coord'(r_ix);
    assign w_iy        = t_coord'(r_iy);
    assign w_rng       = t_coord'(r_range);
    assign w_rad       = t_coord'(r_rad);
    assign w_lo_y      = w_iy - w_rng;
    assign w_hi_x      = w_ix + w_rng;
    assign w_hi_y      = w_iy + w_rng;
    assign w_item_in   = in_grid(w_ix, w_iy);
    assign w_item_addr = cell_addr(w_ix, w_iy);
    assign w_walk_addr = cell_addr(r_wi, r_wj);

    // reclassification of the visited cell
    always_comb begin
        if (r_occ_rd > r_othr) begin
            w_new_cls = OCC_OCCUPIED;
        end else if (r_occ_rd <= r_fthr) begin
            w_new_cls = OCC_FREE;
        end else begin
            w_new_cls = r_cls_rd;
        end
    end

    assign w_hit = r_pv && (r_cls_rd == r_want);

    // status
    assign o_st.clr_last   = &r_clr;
    assign o_st.walk_in    = in_grid(r_wi, r_wj);
    assign o_st.walk_last  = (r_wi == w_hi_x) && (r_wj == w_hi_y);
    assign o_st.eval_mark  = (w_new_cls == OCC_FREE) || (w_new_cls == OCC_OCCUPIED);
    assign o_st.sweep_last = (r_nx == r_wi + w_rad) && (r_ny == r_wj + w_rad);
    assign o_st.out_free   = !r_out_valid || i_m_tready;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range <= RANGE_RST;
            r_othr  <= OCC_THR_RST;
            r_fthr  <= FREE_THR_RST;
            r_fw    <= FW_RST;
            r_dw    <= DW_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_UPDATE_RANGE: r_range <= i_cfg_data[RANGE_W-1:0];
                REG_OCC_THR:      r_othr  <= i_cfg_data[OCC_W-1:0];
                REG_FREE_THR:     r_fthr  <= i_cfg_data[OCC_W-1:0];
                REG_FRONTIER_W:   r_fw    <= i_cfg_data[FW_W-1:0];
                REG_DANGER_W:     r_dw    <= i_cfg_data[DW_W-1:0];
                default: ;
            endcase
        end
    end

    // clearing pass counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    // item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ix   <= i_s_tdata[COORD_W-1:0];
            r_iy   <= i_s_tdata[2*COORD_W-1:COORD_W];
            r_iocc <= i_s_tdata[2*COORD_W+OCC_W-1:2*COORD_W];
        end
    end

    // window walk, columns outer and rows inner
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_wi <= t_coord'(i_s_tdata[COORD_W-1:0]) - w_rng;
            r_wj <= t_coord'(i_s_tdata[2*COORD_W-1:COORD_W]) - w_rng;
        end else if (i_cmd.walk_adv) begin
            if (r_wj == w_hi_y) begin
                r_wj <= w_lo_y;
                r_wi <= r_wi + 1'b1;
            end else begin
                r_wj <= r_wj + 1'b1;
            end
        end
    end

    // neighborhood sweep setup and stepping
    always_ff @(posedge i_clk) begin
        if (i_cmd.cell_eval) begin
            if (w_new_cls == OCC_FREE) begin
                r_rad  <= RAD_W'(r_fw);
                r_nx   <= r_wi - t_coord'(r_fw);
                r_ny   <= r_wj - t_coord'(r_fw);
                r_want <= OCC_UNEXPLORED;
                r_mark <= PLAN_FRONTIER;
            end else begin
                r_rad  <= r_dw;
                r_nx   <= r_wi - t_coord'(r_dw);
                r_ny   <= r_wj - t_coord'(r_dw);
                r_want <= OCC_FREE;
                r_mark <= PLAN_DANGER;
            end
        end else if (i_cmd.sweep_step) begin
            if (r_ny == r_wj + w_rad) begin
                r_ny <= r_wj - w_rad;
                r_nx <= r_nx + 1'b1;
            end else begin
                r_ny <= r_ny + 1'b1;
            end
        end
    end

    // sweep compare stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_cmd.sweep_step && in_grid(r_nx, r_ny);
        end
        r_paddr <= cell_addr(r_nx, r_ny);
    end

    // occupancy store
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            occ_mem[r_clr] <= OCC_INIT;
        end else if (i_cmd.item_write && w_item_in) begin
            occ_mem[w_item_addr] <= r_iocc;
        end
        if (i_cmd.walk_issue) begin
            r_occ_rd <= occ_mem[w_walk_addr];
        end
    end

    // occupancy class store
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            cls_mem[r_clr] <= OCC_UNEXPLORED;
        end else if (i_cmd.cell_eval) begin
            cls_mem[w_walk_addr] <= w_new_cls;
        end
        if (i_cmd.walk_issue) begin
            r_cls_rd <= cls_mem[w_walk_addr];
        end else if (i_cmd.sweep_step) begin
            r_cls_rd <= cls_mem[cell_addr(r_nx, r_ny)];
        end else if (i_cmd.item_read) begin
            r_cls_rd <= cls_mem[w_item_addr];
        end
    end

    // planning class store
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            pln_mem[r_clr] <= PLAN_REGULAR;
        end else if (w_hit) begin
            pln_mem[r_paddr] <= r_mark;
        end
        if (i_cmd.item_read) begin
            r_pln_rd <= pln_mem[w_item_addr];
        end
    end

    // result capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_zero) begin
            r_res_occ  <= OCC_UNEXPLORED;
            r_res_pln  <= PLAN_REGULAR;
            r_res_done <= 1'b0;
        end else if (i_cmd.res_done) begin
            r_res_occ  <= OCC_UNEXPLORED;
            r_res_pln  <= PLAN_REGULAR;
            r_res_done <= 1'b1;
        end else if (i_cmd.res_read) begin
            r_res_occ  <= w_item_in ? r_cls_rd : OCC_UNEXPLORED;
            r_res_pln  <= w_item_in ? r_pln_rd : PLAN_REGULAR;
            r_res_done <= 1'b0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_out_data <= {3'b000, r_res_done, r_res_pln, r_res_occ};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

>>> src/occupancy_grid_frontier_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// occupancy_grid_frontier_classifier
// Occupancy grid with per-cell classes and frontier / danger marking.
// ----------------------------------------------------------------------------
// Update: the window within the update range around the item is walked, columns
// outer; each in-grid cell is read and reclassified, and each free or occupied cell
// gets a sweep of (2*radius+1)^2 neighbors, one neighbor a cycle from the class store.
// One item at a time; a new request is taken once the previous result is queued.
// Reset: a clearing pass writes all 2^(2*ceil(log2(GRID_SIDE))) store addresses
// (4096 at 64) with no request taken; config registers take their reset values at once.
module occupancy_grid_frontier_classifier #(
    parameter int GRID_SIDE = ogfc_pkg::GRID_SIDE_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // x_coord[5:0], y_coord[11:6], occupancy[19:12], zero pad [23:20]
    input  logic [ogfc_pkg::IN_DW-1:0]  s_axis_tdata,
    // mode[1:0]
    input  logic [ogfc_pkg::MODE_W-1:0] s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // occ_class[1:0], plan_class[3:2], done_res[4], zero pad [7:5]
    output logic [ogfc_pkg::OUT_DW-1:0] m_axis_tdata,
    input  logic                        i_cfg_we,
    input  logic [ogfc_pkg::CFG_AW-1:0] i_cfg_addr,
    input  logic [ogfc_pkg::CFG_DW-1:0] i_cfg_data
);
    import ogfc_pkg::*;

    t_cmd  w_cmd;
    t_stat w_st;

    // controller
    ogfc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_mode     (s_axis_tuser),
        .i_st       (w_st),
        .o_s_tready (s_axis_tready),
        .o_cmd      (w_cmd)
    );

    // datapath
    ogfc_dp #(
        .GRID_SIDE (GRID_SIDE)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_st       (w_st),
        .i_s_tdata  (s_axis_tdata),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tdata  (m_axis_tdata)
    );

    // no request taken in the first cycle after reset (clearing pass)
    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !s_axis_tready)
        else $error("request taken during clearing pass");

    // one item at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second request taken while item in work");

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result overwritten before taken");

endmodule
